/* rtl/core/rmth_pkg.sv */
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types and constants for the running median unit.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int VALUE_W  = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 11;

  // rebalance moves allowed per word
  localparam logic [2:0] MAX_MOVES = 3'd4;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } chain_cmd_t;

endpackage

/* rtl/core/running_median_two_heaps_unit.sv */
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit
// Sequence: a refused word goes from accept straight to the finish state; an
//   inserted word first passes through the rebalance state for m moves (at
//   most two are ever needed). Each move shifts both cell chains.
// Input: the next word is taken the cycle after the result loads; in_stall
//   holds off new words until then, and out_stall can hold back the load.
// Reset: rst clears both counts and out_valid; cell contents are not cleared.
// ----------------------------------------------------------------------------
module running_median_two_heaps_unit import rmth_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MEDIAN_W-1:0] median_doubled,
  output logic [COUNT_W-1:0]         stored_count,
  output logic                       refused
);

  localparam int DEPTH = CAPACITY / 2 + 2;
  localparam int SW    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BAL,
    S_FINISH
  } state_t;

  state_t        state;
  logic [SW-1:0] lower_size;
  logic [SW-1:0] upper_size;
  logic [2:0]    moves;
  logic          refused_r;

  value_t     ltop;
  value_t     utop;
  chain_cmd_t lower_cmd;
  chain_cmd_t upper_cmd;
  value_t     lower_ins;

  logic [SW:0]    total;
  logic [SW+11:0] total_ext;
  logic           full;
  logic           accept;
  logic           load;
  logic           l_heavy;
  logic           u_heavy;
  logic           crossed;
  logic           mv_down;
  logic           mv_up;
  logic signed [MEDIAN_W-1:0] med_next;

  always_comb begin
    total     = {1'b0, lower_size} + {1'b0, upper_size};
    total_ext = (SW+12)'(total);
    full      = total >= (SW+1)'(CAPACITY);
    in_stall  = state != S_IDLE;
    accept    = in_valid && !in_stall;
    load      = (state == S_FINISH) && (!out_valid || !out_stall);

    l_heavy = {1'b0, lower_size} > ({1'b0, upper_size} + (SW+1)'(1));
    u_heavy = {1'b0, upper_size} > ({1'b0, lower_size} + (SW+1)'(1));
    crossed = (lower_size != '0) && (upper_size != '0) && (ltop > utop);

    mv_down = (state == S_BAL) && (moves != MAX_MOVES) && (l_heavy || (!u_heavy && crossed));
    mv_up   = (state == S_BAL) && (moves != MAX_MOVES) && !l_heavy && u_heavy;

    lower_cmd.insert = (accept && !full) || mv_up;
    lower_cmd.pop    = mv_down;
    lower_ins        = accept ? value : utop;
    upper_cmd.insert = mv_down;
    upper_cmd.pop    = mv_up;

    if (total == '0) begin
      med_next = '0;
    end else if (!total[0]) begin
      med_next = {ltop[VALUE_W-1], ltop} + {utop[VALUE_W-1], utop};
    end else if (lower_size > upper_size) begin
      med_next = {ltop, 1'b0};
    end else begin
      med_next = {utop, 1'b0};
    end
  end

  rmth_chain #(
    .IS_MAX (1'b1),
    .DEPTH  (DEPTH),
    .SW     (SW)
  ) u_lower (
    .clk       (clk),
    .cmd       (lower_cmd),
    .ins_value (lower_ins),
    .size      (lower_size),
    .top_value (ltop)
  );

  rmth_chain #(
    .IS_MAX (1'b0),
    .DEPTH  (DEPTH),
    .SW     (SW)
  ) u_upper (
    .clk       (clk),
    .cmd       (upper_cmd),
    .ins_value (ltop),
    .size      (upper_size),
    .top_value (utop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      lower_size <= '0;
      upper_size <= '0;
      moves      <= '0;
      refused_r  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            moves     <= '0;
            refused_r <= full;
            if (full) begin
              state <= S_FINISH;
            end else begin
              lower_size <= lower_size + SW'(1);
              state      <= S_BAL;
            end
          end
        end
        S_BAL: begin
          if (mv_down) begin
            lower_size <= lower_size - SW'(1);
            upper_size <= upper_size + SW'(1);
            moves      <= moves + 3'd1;
          end else if (mv_up) begin
            lower_size <= lower_size + SW'(1);
            upper_size <= upper_size - SW'(1);
            moves      <= moves + 3'd1;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load) begin
            median_doubled <= med_next;
            stored_count   <= total_ext[COUNT_W-1:0];
            refused        <= refused_r;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/rmth_cell.sv */
// ----------------------------------------------------------------------------
// rmth_cell
// One slot of a sorted chain: takes the previous neighbor's value or the new value on insert, the next one's on pop.
// ----------------------------------------------------------------------------
module rmth_cell import rmth_pkg::*; #(
  parameter bit IS_MAX = 1'b1,
  parameter int SW     = 10,
  parameter int IDX    = 0
) (
  input  logic          clk,
  input  chain_cmd_t    cmd,
  input  value_t        ins_value,
  input  value_t        prev_value,
  input  logic          prev_beats,
  input  value_t        next_value,
  input  logic [SW-1:0] size,
  output value_t        value,
  output logic          beats
);

  localparam logic [SW-1:0] IDX_L = SW'(IDX);

  logic occupied;
  logic ranks;

  always_comb begin
    occupied = IDX_L < size;
    ranks    = IS_MAX ? (ins_value > value) : (ins_value < value);
    beats    = !occupied || ranks;
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (beats) begin
        value <= prev_beats ? prev_value : ins_value;
      end
    end else if (cmd.pop) begin
      value <= next_value;
    end
  end

endmodule

/* rtl/core/rmth_chain.sv */
// ----------------------------------------------------------------------------
// rmth_chain
// Row of cells kept in order; the top of the half sits in the first cell.
// ----------------------------------------------------------------------------
module rmth_chain import rmth_pkg::*; #(
  parameter bit IS_MAX = 1'b1,
  parameter int DEPTH  = 514,
  parameter int SW     = 10
) (
  input  logic          clk,
  input  chain_cmd_t    cmd,
  input  value_t        ins_value,
  input  logic [SW-1:0] size,
  output value_t        top_value
);

  value_t vals  [DEPTH];
  logic   beats [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t prev_v;
    logic   prev_b;
    value_t next_v;

    if (i == 0) begin : g_first
      assign prev_v = ins_value;
      assign prev_b = 1'b0;
    end else begin : g_mid
      assign prev_v = vals[i-1];
      assign prev_b = beats[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = vals[i];
    end else begin : g_inner
      assign next_v = vals[i+1];
    end

    rmth_cell #(
      .IS_MAX (IS_MAX),
      .SW     (SW),
      .IDX    (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .ins_value  (ins_value),
      .prev_value (prev_v),
      .prev_beats (prev_b),
      .next_value (next_v),
      .size       (size),
      .value      (vals[i]),
      .beats      (beats[i])
    );
  end

  assign top_value = vals[0];

endmodule

/* rtl/core/rmth_checker.sv */
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks on the running median unit, bound to the top level.
// ----------------------------------------------------------------------------
module rmth_checker import rmth_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [VALUE_W-1:0]  value,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [MEDIAN_W-1:0] median_doubled,
  input logic [COUNT_W-1:0]         stored_count,
  input logic                       refused
);

  localparam logic [COUNT_W+31:0] CAP_EXT = (COUNT_W+32)'(CAPACITY);
  localparam logic [COUNT_W-1:0]  CAP_CNT = CAP_EXT[COUNT_W-1:0];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median_doubled)
      && $stable(stored_count) && $stable(refused))
    else $error("stalled output word changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && refused |-> stored_count == CAP_CNT)
    else $error("refused word without a full store");

  a_odd_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && stored_count[0] |-> !median_doubled[0])
    else $error("odd count gave a half median");

endmodule

bind running_median_two_heaps_unit rmth_checker #(.CAPACITY(CAPACITY)) u_rmth_checker (.*);
